FILE: design/polygon_fan_triangulator_unit_assert.svh
// assertion macros used by the checker file
`ifndef POLYGON_FAN_TRIANGULATOR_UNIT_ASSERT_SVH
`define POLYGON_FAN_TRIANGULATOR_UNIT_ASSERT_SVH

// implication checked outside reset
`define PFT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polygon fan triangulator check failed");

// next-cycle implication checked outside reset
`define PFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("polygon fan triangulator check failed");

// next-cycle implication that also holds across reset
`define PFT_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("polygon fan triangulator check failed");

`endif

FILE: design/pft_pkg.sv
`default_nettype none

package pft_pkg;

  // result kinds
  localparam logic KIND_TRIANGLE = 1'b0;
  localparam logic KIND_DRAW     = 1'b1;

  // register indexes
  localparam logic REG_INDEX_CAPACITY = 1'b0;

  // edge position within a face, saturating at the fan position
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_FAN    = 2'd2;

  // indices per triangle
  localparam int TRI_INDICES = 3;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

endpackage

`default_nettype wire

FILE: design/pft_edge_if.sv
`default_nettype none

interface pft_edge_if #(
  parameter int VERTEX_INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [VERTEX_INDEX_BITS-1:0] edge_start_vertex;
  logic [VERTEX_INDEX_BITS-1:0] edge_end_vertex;
  logic                         edge_reversed;
  logic                         face_last_edge;
  logic                         face_skipped;

  modport source (
    output valid, edge_start_vertex, edge_end_vertex, edge_reversed,
           face_last_edge, face_skipped,
    input  ready
  );

  modport sink (
    input  valid, edge_start_vertex, edge_end_vertex, edge_reversed,
           face_last_edge, face_skipped,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/pft_result_if.sv
`default_nettype none

interface pft_result_if #(
  parameter int VERTEX_INDEX_BITS = 16,
  parameter int INDEX_COUNT_BITS  = 24
);
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [VERTEX_INDEX_BITS-1:0] corner_a;
  logic [VERTEX_INDEX_BITS-1:0] corner_b;
  logic [VERTEX_INDEX_BITS-1:0] corner_c;
  logic [INDEX_COUNT_BITS-1:0]  draw_index_count;
  logic [INDEX_COUNT_BITS-1:0]  draw_first_index;
  logic                         last_of_run;

  modport source (
    output valid, result_kind, corner_a, corner_b, corner_c,
           draw_index_count, draw_first_index, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, result_kind, corner_a, corner_b, corner_c,
           draw_index_count, draw_first_index, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/polygon_fan_triangulator_unit.sv
// channel   dir  beat                                       handshake
// edge_in   in   one signed polygon edge                    valid/ready
// res_out   out  one fan triangle or one face draw record   valid/ready
// apb       in   index_capacity register, byte address 0    psel/penable, pready high
//
// one edge is taken per cycle; state update, capacity add/compare and result
// build sit between the edge state registers and a 4-entry result queue
// an edge giving a triangle and a draw record pushes two beats, so the
// output side sets the rate at which such edges can be taken;
// edge_in.ready drops while fewer than two queue slots are free
// rst (synchronous) empties the queue, clears face state, capacity to all ones
`default_nettype none

module polygon_fan_triangulator_unit
  import pft_pkg::*;
#(
  parameter int VERTEX_INDEX_BITS = 16,
  parameter int INDEX_COUNT_BITS  = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  pft_edge_if.sink                      edge_in,
  pft_result_if.source                  res_out,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int V = VERTEX_INDEX_BITS;
  localparam int C = INDEX_COUNT_BITS;
  localparam int QDEPTH = 4;
  localparam int QPTR = $clog2(QDEPTH);

  typedef struct packed {
    logic         kind;
    logic [V-1:0] a;
    logic [V-1:0] b;
    logic [V-1:0] c;
    logic [C-1:0] cnt;
    logic [C-1:0] first;
    logic         last;
  } entry_t;

  logic [C-1:0]  index_capacity;
  logic [V-1:0]  apex_vertex, apex_vertex_next;
  logic [V-1:0]  previous_vertex, previous_vertex_next;
  logic [1:0]    edge_position, edge_position_next;
  logic [C-1:0]  running_index_count, running_index_count_next;
  logic [C-1:0]  face_start_position, face_start_position_next;

  entry_t        queue [QDEPTH];
  logic [QPTR-1:0] wr_ptr, rd_ptr;
  logic [QPTR:0]   fill;

  logic          accept, pop;
  logic [V-1:0]  cur;
  logic [C:0]    run_plus;
  logic          tri_fire;
  logic [C-1:0]  start_eff;
  logic [1:0]    push_n;
  entry_t        tri_entry, draw_entry, e0, e1;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_INDEX_CAPACITY) prdata = APB_DATA_BITS'(index_capacity);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_capacity <= '1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_INDEX_CAPACITY) begin
      index_capacity <= pwdata[C-1:0];
    end
  end

  assign edge_in.ready = (fill < (QPTR+1)'(QDEPTH - 1));
  assign accept = edge_in.valid && edge_in.ready;
  assign pop = res_out.valid && res_out.ready;

  assign cur = edge_in.edge_reversed ? edge_in.edge_end_vertex : edge_in.edge_start_vertex;
  assign run_plus = {1'b0, running_index_count} + (C+1)'(TRI_INDICES);
  assign tri_fire = (edge_position == POS_FAN) && (run_plus <= {1'b0, index_capacity});
  assign start_eff = (edge_position == POS_FIRST) ? running_index_count : face_start_position;

  always_comb begin
    apex_vertex_next         = apex_vertex;
    previous_vertex_next     = previous_vertex;
    edge_position_next       = edge_position;
    running_index_count_next = running_index_count;
    face_start_position_next = face_start_position;

    tri_entry = '0;
    tri_entry.kind = KIND_TRIANGLE;
    tri_entry.a = apex_vertex;
    tri_entry.b = previous_vertex;
    tri_entry.c = cur;
    tri_entry.last = !edge_in.face_last_edge;

    draw_entry = '0;
    draw_entry.kind = KIND_DRAW;
    draw_entry.last = 1'b1;

    e0 = draw_entry;
    e1 = draw_entry;
    push_n = 2'd0;

    if (edge_in.face_skipped) begin
      // skipped face: zero record on its last edge, state untouched otherwise
      if (edge_in.face_last_edge) begin
        push_n = 2'd1;
        edge_position_next = POS_FIRST;
      end
    end else begin
      if (edge_position == POS_FIRST) begin
        apex_vertex_next = cur;
        face_start_position_next = running_index_count;
      end
      if (tri_fire) running_index_count_next = run_plus[C-1:0];
      previous_vertex_next = cur;
      if (edge_position != POS_FAN) edge_position_next = edge_position + 2'd1;

      draw_entry.cnt = running_index_count_next - start_eff;
      draw_entry.first = start_eff;

      if (edge_in.face_last_edge) edge_position_next = POS_FIRST;

      if (tri_fire) begin
        e0 = tri_entry;
        e1 = draw_entry;
        push_n = edge_in.face_last_edge ? 2'd2 : 2'd1;
      end else begin
        e0 = draw_entry;
        push_n = edge_in.face_last_edge ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      apex_vertex         <= '0;
      previous_vertex     <= '0;
      edge_position       <= POS_FIRST;
      running_index_count <= '0;
      face_start_position <= '0;
    end else if (accept) begin
      apex_vertex         <= apex_vertex_next;
      previous_vertex     <= previous_vertex_next;
      edge_position       <= edge_position_next;
      running_index_count <= running_index_count_next;
      face_start_position <= face_start_position_next;
    end
  end

  // result queue: up to two pushes, one pop per cycle
  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) queue[wr_ptr] <= e0;
    if (accept && push_n == 2'd2) queue[wr_ptr + QPTR'(1)] <= e1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + QPTR'(push_n);
      if (pop) rd_ptr <= rd_ptr + QPTR'(1);
      fill <= fill + (accept ? (QPTR+1)'(push_n) : '0) - (QPTR+1)'(pop);
    end
  end

  assign res_out.valid            = (fill != '0);
  assign res_out.result_kind      = queue[rd_ptr].kind;
  assign res_out.corner_a         = queue[rd_ptr].a;
  assign res_out.corner_b         = queue[rd_ptr].b;
  assign res_out.corner_c         = queue[rd_ptr].c;
  assign res_out.draw_index_count = queue[rd_ptr].cnt;
  assign res_out.draw_first_index = queue[rd_ptr].first;
  assign res_out.last_of_run      = queue[rd_ptr].last;

endmodule

`default_nettype wire

FILE: design/pft_checker.sv
`default_nettype none

`include "polygon_fan_triangulator_unit_assert.svh"

module pft_checker
  import pft_pkg::*;
#(
  parameter int VERTEX_INDEX_BITS = 16,
  parameter int INDEX_COUNT_BITS  = 24
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_kind,
  input wire logic [VERTEX_INDEX_BITS-1:0] out_a,
  input wire logic [INDEX_COUNT_BITS-1:0]  out_cnt,
  input wire logic [INDEX_COUNT_BITS-1:0]  out_first,
  input wire logic                         out_last,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [APB_ADDR_BITS-1:0]     paddr,
  input wire logic [APB_DATA_BITS-1:0]     pwdata,
  input wire logic [APB_DATA_BITS-1:0]     prdata
);

  localparam int C = INDEX_COUNT_BITS;

  // nothing is offered right after reset
  `PFT_ASSERT_RST(a_empty_after_reset, clk, rst, !out_valid)

  // a stalled beat holds
  `PFT_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_a) && $stable(out_cnt) &&
    $stable(out_first) && $stable(out_last))

  // a draw record always closes the run of its edge
  `PFT_ASSERT_IMP(a_draw_is_last, clk, rst, out_valid && out_kind == KIND_DRAW, out_last)

  // capacity readback after a write
  `PFT_ASSERT_IMP(a_capacity_readback, clk, rst,
    (psel && penable && pwrite && paddr[2] == REG_INDEX_CAPACITY) ##1
    (!pwrite && paddr[2] == REG_INDEX_CAPACITY),
    prdata == APB_DATA_BITS'($past(pwdata[C-1:0])))

endmodule

bind polygon_fan_triangulator_unit pft_checker #(
  .VERTEX_INDEX_BITS(VERTEX_INDEX_BITS),
  .INDEX_COUNT_BITS (INDEX_COUNT_BITS)
) u_pft_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(res_out.valid),
  .out_ready(res_out.ready),
  .out_kind (res_out.result_kind),
  .out_a    (res_out.corner_a),
  .out_cnt  (res_out.draw_index_count),
  .out_first(res_out.draw_first_index),
  .out_last (res_out.last_of_run),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

`default_nettype wire
